[sv/art_pkg.sv]
// shared types and constants for the ack retransmit tracker
package art_pkg;

  localparam int SEQ_W = 32;
  localparam int TMR_W = 16;
  localparam int MAX_RESULTS = 16;

  typedef enum logic [2:0] {
    CMD_SEND    = 3'd0,
    CMD_RECEIVE = 3'd1,
    CMD_ACK     = 3'd2,
    CMD_TICK    = 3'd3,
    CMD_FLUSH   = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    K_ASSIGNED     = 4'd0,
    K_ACCEPTED     = 4'd1,
    K_OUT_OF_ORDER = 4'd2,
    K_ACK_MATCHED  = 4'd3,
    K_ACK_UNKNOWN  = 4'd4,
    K_ACK_OUT      = 4'd5,
    K_RETRANSMIT   = 4'd6,
    K_DONE         = 4'd7,
    K_REFUSED      = 4'd8
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK_SCAN,
    ST_TICK_SCAN,
    ST_FLUSH,
    ST_EMIT
  } state_t;

  // per-cycle control broadcast to the pending cells
  typedef struct packed {
    logic            append;
    logic            shift;
    logic            rotate;
    logic            fire;
    logic [SEQ_W-1:0] seq_in;
  } pend_ctl_t;

endpackage

[sv/ack_retransmit_tracker.sv]
// top level of the ack retransmit tracker: control, pending and ack cell rows, output register
// Send, receive and unused commands pass from idle through the emit state to the next acceptance.
// Ack walks the pending row one entry per cycle and then shifts the tail over the match; tick
// rotates the row through its head cell. A flush shifts the ack row one word per cycle while
// the output register is free, as it emits. One item is in work at a time; each result word
// waits in the output register until taken, which stalls the work. The timeout register
// resets to 1000 ticks.
module ack_retransmit_tracker import art_pkg::*; #(
  parameter int PENDING_DEPTH = 16,
  parameter int ACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_seq_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_kind,
  output logic [31:0] out_seq_number_out,
  output logic        out_last,
  output logic        out_acks_waiting,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_timeout_ticks
);

  localparam int PW = $clog2(PENDING_DEPTH + 1);
  localparam int AW = $clog2(ACK_DEPTH + 1);
  localparam int RW = $clog2(MAX_RESULTS + 1);

  state_t           state_r, state_nxt;
  logic [TMR_W-1:0] timeout_r;
  logic [SEQ_W-1:0] send_seq_r, send_seq_nxt;
  logic [SEQ_W-1:0] exp_seq_r, exp_seq_nxt;
  logic [PW-1:0]    pcnt_r, pcnt_nxt;
  logic [AW-1:0]    acnt_r, acnt_nxt;
  logic [PW-1:0]    idx_r, idx_nxt;
  logic [RW-1:0]    nres_r, nres_nxt;
  logic             found_r, found_nxt;
  logic [2:0]       cmd_r;
  logic [SEQ_W-1:0] seq_r;
  logic             ov_r, ov_nxt;
  logic [3:0]       ok_r, ok_nxt;
  logic [SEQ_W-1:0] os_r, os_nxt;
  logic             ol_r, ol_nxt;
  logic             oa_r, oa_nxt;
  logic [3:0]       ek_r, ek_nxt;
  logic [SEQ_W-1:0] es_r, es_nxt;

  pend_ctl_t        pctl;
  logic [PW-1:0]    shift_from;
  logic             ack_load, ack_shift;

  logic [SEQ_W-1:0] p_seq [PENDING_DEPTH];
  logic [TMR_W-1:0] p_tmr [PENDING_DEPTH];
  logic [SEQ_W-1:0] a_seq [ACK_DEPTH];

  logic             out_free;
  logic [TMR_W-1:0] head_inc;
  logic             head_fire;

  assign out_free  = !ov_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_kind = ok_r;
  assign out_seq_number_out = os_r;
  assign out_last = ol_r;
  assign out_acks_waiting = oa_r;

  assign head_inc  = (p_tmr[0] != {TMR_W{1'b1}}) ? p_tmr[0] + 1'b1 : p_tmr[0];
  assign head_fire = (head_inc >= timeout_r) && (nres_r < RW'(MAX_RESULTS));

  genvar g;
  generate
    for (g = 0; g < PENDING_DEPTH; g++) begin : g_pend
      logic [SEQ_W-1:0] nbs;
      logic [TMR_W-1:0] nbt;
      logic             tail, take;
      always_comb begin
        if (pctl.rotate && (PW'(g) == pcnt_r - 1'b1)) begin
          nbs = p_seq[0];
          nbt = p_tmr[0];
        end else if (g == PENDING_DEPTH - 1) begin
          nbs = p_seq[g];
          nbt = p_tmr[g];
        end else begin
          nbs = p_seq[(g + 1) % PENDING_DEPTH];
          nbt = p_tmr[(g + 1) % PENDING_DEPTH];
        end
        tail = pctl.append ? (PW'(g) == pcnt_r) : (PW'(g) == pcnt_r - 1'b1);
        take = pctl.shift ? (PW'(g) >= shift_from) : (PW'(g) < pcnt_r - 1'b1);
      end
      art_pend_cell u_cell (
        .clk(clk), .ctl(pctl), .is_tail(tail),
        .take_neighbor(take), .nb_seq(nbs), .nb_tmr(nbt),
        .seq_r(p_seq[g]), .tmr_r(p_tmr[g])
      );
    end
    for (g = 0; g < ACK_DEPTH; g++) begin : g_ack
      logic [SEQ_W-1:0] nbs;
      assign nbs = (g == ACK_DEPTH - 1) ? a_seq[g] : a_seq[(g + 1) % ACK_DEPTH];
      art_ack_cell u_cell (
        .clk(clk), .load(ack_load && (AW'(g) == acnt_r)), .shift(ack_shift),
        .load_seq(seq_r), .nb_seq(nbs), .seq_r(a_seq[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    send_seq_nxt = send_seq_r;
    exp_seq_nxt = exp_seq_r;
    pcnt_nxt = pcnt_r;
    acnt_nxt = acnt_r;
    idx_nxt = idx_r;
    nres_nxt = nres_r;
    found_nxt = found_r;
    ek_nxt = ek_r;
    es_nxt = es_r;
    ov_nxt = ov_r && !out_ready;
    ok_nxt = ok_r;
    os_nxt = os_r;
    ol_nxt = ol_r;
    oa_nxt = oa_r;
    pctl = '0;
    pctl.seq_in = send_seq_r;
    pctl.fire = head_fire;
    shift_from = '0;
    ack_load = 1'b0;
    ack_shift = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          idx_nxt = '0;
          nres_nxt = '0;
          found_nxt = 1'b0;
          unique case (in_command)
            CMD_ACK:   state_nxt = ST_ACK_SCAN;
            CMD_TICK:  state_nxt = ST_TICK_SCAN;
            CMD_FLUSH: state_nxt = ST_FLUSH;
            default:   state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_EMIT: begin
        // single-result commands
        if (out_free) begin
          ov_nxt = 1'b1;
          ol_nxt = 1'b1;
          ok_nxt = K_DONE;
          os_nxt = '0;
          case (cmd_r)
            CMD_SEND: begin
              if (pcnt_r >= PW'(PENDING_DEPTH)) begin
                ok_nxt = K_REFUSED;
              end else begin
                pctl.append = 1'b1;
                pcnt_nxt = pcnt_r + 1'b1;
                ok_nxt = K_ASSIGNED;
                os_nxt = send_seq_r;
                send_seq_nxt = send_seq_r + 1'b1;
              end
            end
            CMD_RECEIVE: begin
              os_nxt = seq_r;
              if (seq_r != exp_seq_r) begin
                ok_nxt = K_OUT_OF_ORDER;
              end else if (acnt_r >= AW'(ACK_DEPTH)) begin
                ok_nxt = K_REFUSED;
              end else begin
                ack_load = 1'b1;
                acnt_nxt = acnt_r + 1'b1;
                exp_seq_nxt = exp_seq_r + 1'b1;
                ok_nxt = K_ACCEPTED;
              end
            end
            CMD_ACK: begin
              ok_nxt = found_r ? K_ACK_MATCHED : K_ACK_UNKNOWN;
              os_nxt = seq_r;
            end
            default: ok_nxt = K_DONE;
          endcase
          oa_nxt = (acnt_nxt != '0);
          state_nxt = ST_IDLE;
        end
      end
      ST_ACK_SCAN: begin
        // compare one entry per cycle, then shift the tail over the match
        if (!found_r && idx_r < pcnt_r) begin
          if (p_seq[idx_r[$clog2(PENDING_DEPTH)-1:0]] == seq_r) found_nxt = 1'b1;
          else idx_nxt = idx_r + 1'b1;
        end else begin
          if (found_r) begin
            pctl.shift = 1'b1;
            shift_from = idx_r;
            pcnt_nxt = pcnt_r - 1'b1;
          end
          state_nxt = ST_EMIT;
        end
      end
      ST_TICK_SCAN: begin
        // rotate the row through its head cell, one entry per cycle unless a firing head waits on a full output
        if (idx_r < pcnt_r) begin
          if (!(head_fire && ov_r && !out_ready)) begin
            pctl.rotate = 1'b1;
            idx_nxt = idx_r + 1'b1;
            if (head_fire) begin
              if (nres_r != '0) begin
                ov_nxt = 1'b1;
                ok_nxt = ek_r;
                os_nxt = es_r;
                ol_nxt = 1'b0;
                oa_nxt = (acnt_r != '0);
              end
              ek_nxt = K_RETRANSMIT;
              es_nxt = p_seq[0];
              nres_nxt = nres_r + 1'b1;
            end
          end
        end else if (out_free) begin
          ov_nxt = 1'b1;
          ol_nxt = 1'b1;
          oa_nxt = (acnt_r != '0);
          ok_nxt = (nres_r != '0) ? ek_r : K_DONE;
          os_nxt = (nres_r != '0) ? es_r : '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          if (acnt_r == '0 || nres_r == RW'(MAX_RESULTS)) begin
            // empty queue, or the cap was reached on the word already sent
            ok_nxt = K_DONE;
            os_nxt = '0;
            ol_nxt = 1'b1;
            oa_nxt = (acnt_r != '0);
            if (nres_r != '0) ov_nxt = ov_r && !out_ready;
            state_nxt = ST_IDLE;
          end else begin
            ack_shift = 1'b1;
            acnt_nxt = acnt_r - 1'b1;
            nres_nxt = nres_r + 1'b1;
            ok_nxt = K_ACK_OUT;
            os_nxt = a_seq[0];
            ol_nxt = (acnt_nxt == '0) || (nres_nxt == RW'(MAX_RESULTS));
            // acks left once this flush is over
            oa_nxt = (32'(acnt_r) + 32'(nres_r)) > 32'(MAX_RESULTS);
            if (ol_nxt) state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      timeout_r <= 16'd1000;
      send_seq_r <= '0;
      exp_seq_r <= '0;
      pcnt_r <= '0;
      acnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      send_seq_r <= send_seq_nxt;
      exp_seq_r <= exp_seq_nxt;
      pcnt_r <= pcnt_nxt;
      acnt_r <= acnt_nxt;
      ov_r <= ov_nxt;
      if (cfg_valid) timeout_r <= cfg_timeout_ticks;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    nres_r <= nres_nxt;
    found_r <= found_nxt;
    ek_r <= ek_nxt;
    es_r <= es_nxt;
    ok_r <= ok_nxt;
    os_r <= os_nxt;
    ol_r <= ol_nxt;
    oa_r <= oa_nxt;
    if (state_r == ST_IDLE && in_valid) begin
      cmd_r <= in_command;
      seq_r <= in_seq_number;
    end
  end

endmodule

[sv/art_pend_cell.sv]
// one pending entry cell: holds a sequence number and a timer, passes to its neighbor
module art_pend_cell import art_pkg::*; (
  input  logic             clk,
  input  pend_ctl_t        ctl,
  input  logic             is_tail,
  input  logic             take_neighbor,
  input  logic [SEQ_W-1:0] nb_seq,
  input  logic [TMR_W-1:0] nb_tmr,
  output logic [SEQ_W-1:0] seq_r,
  output logic [TMR_W-1:0] tmr_r
);

  logic [SEQ_W-1:0] seq_nxt;
  logic [TMR_W-1:0] tmr_nxt;
  logic [TMR_W-1:0] head_tmr;

  always_comb begin
    head_tmr = nb_tmr;
    if (nb_tmr != {TMR_W{1'b1}}) head_tmr = nb_tmr + 1'b1;
    if (ctl.fire) head_tmr = '0;
    seq_nxt = seq_r;
    tmr_nxt = tmr_r;
    if (ctl.append && is_tail) begin
      seq_nxt = ctl.seq_in;
      tmr_nxt = '0;
    end else if (ctl.shift && take_neighbor) begin
      seq_nxt = nb_seq;
      tmr_nxt = nb_tmr;
    end else if (ctl.rotate) begin
      if (is_tail) begin
        // the head entry wraps to the last occupied place, ticked, or cleared when it fires
        seq_nxt = nb_seq;
        tmr_nxt = head_tmr;
      end else if (take_neighbor) begin
        seq_nxt = nb_seq;
        tmr_nxt = nb_tmr;
      end
    end
  end

  always_ff @(posedge clk) begin
    seq_r <= seq_nxt;
    tmr_r <= tmr_nxt;
  end

endmodule

[sv/art_ack_cell.sv]
// one ack queue cell: holds a queued number, shifts toward the head
module art_ack_cell import art_pkg::*; (
  input  logic             clk,
  input  logic             load,
  input  logic             shift,
  input  logic [SEQ_W-1:0] load_seq,
  input  logic [SEQ_W-1:0] nb_seq,
  output logic [SEQ_W-1:0] seq_r
);

  logic [SEQ_W-1:0] seq_nxt;

  always_comb begin
    seq_nxt = seq_r;
    if (load) seq_nxt = load_seq;
    else if (shift) seq_nxt = nb_seq;
  end

  always_ff @(posedge clk) begin
    seq_r <= seq_nxt;
  end

endmodule

[tb/tb.sv]
// testbench for the ack retransmit tracker: directed table, random traffic, predictor and checker
module tb import art_pkg::*; ;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] seq;
  } item_t;

  typedef struct {
    logic [3:0]  kind;
    logic [31:0] seq;
    logic        last;
    logic        waiting;
  } word_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] seq;
    logic        typed;
    logic [3:0]  kind;
    logic [31:0] kseq;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_command;
  logic [31:0] in_seq_number;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  out_kind;
  logic [31:0] out_seq_number_out;
  logic        out_last;
  logic        out_acks_waiting;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_timeout_ticks;

  ack_retransmit_tracker uut (.*);

  // predictor state
  logic [15:0] p_timeout;
  logic [31:0] p_send_seq;
  logic [31:0] p_expect_seq;
  logic [31:0] p_pend_seq[$];
  logic [15:0] p_pend_tmr[$];
  logic [31:0] p_acks[$];

  word_t       expected_words[$];
  item_t       send_q[$];
  int          errors;
  int          words_seen;
  int          cycles;
  bit          hold_off;
  bit          no_idle;
  bit          stim_done;
  bit          in_taken;

  task automatic push_word(input logic [3:0] k, input logic [31:0] s);
    word_t w;
    w.kind = k;
    w.seq = s;
    w.last = 1'b0;
    w.waiting = 1'b0;
    expected_words = {expected_words, w};
  endtask

  task automatic predict_item(input item_t it);
    int n;
    int first;
    int take;
    bit found;
    first = expected_words.size();
    n = 0;
    case (it.cmd)
      CMD_SEND: begin
        if (p_pend_seq.size() >= 16) begin
          push_word(K_REFUSED, 32'd0);
        end else begin
          p_pend_seq = {p_pend_seq, p_send_seq};
          p_pend_tmr = {p_pend_tmr, 16'd0};
          push_word(K_ASSIGNED, p_send_seq);
          p_send_seq++;
        end
      end
      CMD_RECEIVE: begin
        if (it.seq != p_expect_seq) push_word(K_OUT_OF_ORDER, it.seq);
        else if (p_acks.size() >= 16) push_word(K_REFUSED, it.seq);
        else begin
          p_acks = {p_acks, it.seq};
          p_expect_seq++;
          push_word(K_ACCEPTED, it.seq);
        end
      end
      CMD_ACK: begin
        found = 0;
        foreach (p_pend_seq[i]) begin
          if (!found && p_pend_seq[i] == it.seq) begin
            p_pend_seq.delete(i);
            p_pend_tmr.delete(i);
            found = 1;
            break;
          end
        end
        push_word(found ? K_ACK_MATCHED : K_ACK_UNKNOWN, it.seq);
      end
      CMD_TICK: begin
        foreach (p_pend_tmr[i]) begin
          if (p_pend_tmr[i] != 16'hffff) p_pend_tmr[i]++;
          if (p_pend_tmr[i] >= p_timeout && n < MAX_RESULTS) begin
            push_word(K_RETRANSMIT, p_pend_seq[i]);
            p_pend_tmr[i] = 16'd0;
            n++;
          end
        end
        if (n == 0) push_word(K_DONE, 32'd0);
      end
      CMD_FLUSH: begin
        take = p_acks.size() > MAX_RESULTS ? MAX_RESULTS : p_acks.size();
        for (int i = 0; i < take; i++) push_word(K_ACK_OUT, p_acks.pop_front());
        if (take == 0) push_word(K_DONE, 32'd0);
      end
      default: push_word(K_DONE, 32'd0);
    endcase
    for (int i = first; i < expected_words.size(); i++)
      expected_words[i].waiting = p_acks.size() > 0;
    expected_words[expected_words.size()-1].last = 1'b1;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // input side
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
    end else if (send_q.size() > 0 && (no_idle || $urandom_range(99) >= 33)) begin
      in_valid <= 1'b1;
      in_command <= send_q[0].cmd;
      in_seq_number <= send_q[0].seq;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    in_taken = rst_n && in_valid && in_ready;
    if (in_taken) begin
      predict_item(send_q[0]);
      void'(send_q.pop_front());
    end
  end

  // output side
  always @(negedge clk) begin
    if (!rst_n || hold_off) out_ready <= 1'b0;
    else out_ready <= no_idle || $urandom_range(99) >= 33;
  end

  always @(posedge clk) begin
    word_t e;
    if (rst_n && out_valid && out_ready) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t unexpected word: kind %0d seq %0d", $time, out_kind, out_seq_number_out);
      end else begin
        e = expected_words.pop_front();
        if (out_kind !== e.kind || out_seq_number_out !== e.seq || out_last !== e.last ||
            out_acks_waiting !== e.waiting) begin
          errors++;
          $display("%0t mismatch: expected kind %0d seq %0d last %0b wait %0b, got %0d %0d %0b %0b",
                   $time, e.kind, e.seq, e.last, e.waiting, out_kind, out_seq_number_out,
                   out_last, out_acks_waiting);
        end
      end
    end
  end

  task automatic enqueue(input logic [2:0] c, input logic [31:0] s);
    item_t it;
    it.cmd = c;
    it.seq = s;
    send_q = {send_q, it};
  endtask

  task automatic drain();
    while (send_q.size() > 0 || in_valid || expected_words.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_timeout_ticks <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    p_timeout = v;
  endtask

  task automatic random_phase(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 25) enqueue(CMD_SEND, $urandom);
      else if (r < 45) enqueue(CMD_RECEIVE, $urandom_range(3) != 0 ? p_expect_seq + send_q.size()
                                           * 0 : $urandom);
      else if (r < 65) enqueue(CMD_ACK, ($urandom_range(3) != 0) ? p_send_seq -
                                          $urandom_range(8) : $urandom);
      else if (r < 85) enqueue(CMD_TICK, $urandom);
      else if (r < 97) enqueue(CMD_FLUSH, $urandom);
      else enqueue(3'($urandom_range(7, 5)), $urandom);
      drain_one();
    end
  endtask

  // items go one at a time here so receive and ack numbers track the predicted state
  task automatic drain_one();
    while (send_q.size() > 0 || in_valid) @(posedge clk);
  endtask

  row_t table_rows[$];

  task automatic row(input logic [2:0] c, input logic [31:0] s, input bit t,
                     input logic [3:0] k, input logic [31:0] ks);
    row_t r;
    r.cmd = c;
    r.seq = s;
    r.typed = t;
    r.kind = k;
    r.kseq = ks;
    table_rows = {table_rows, r};
  endtask

  initial begin
    int base;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_taken = 1'b0;
    in_command = '0;
    in_seq_number = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_timeout_ticks = '0;
    errors = 0;
    words_seen = 0;
    hold_off = 0;
    no_idle = 0;
    p_timeout = 16'd1000;
    p_send_seq = 0;
    p_expect_seq = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table, typed results only where obvious
    row(CMD_TICK, 0, 1, K_DONE, 0);
    row(CMD_FLUSH, 0, 1, K_DONE, 0);
    row(3'd5, 32'hffffffff, 1, K_DONE, 0);
    row(3'd7, 0, 1, K_DONE, 0);
    row(CMD_RECEIVE, 32'hffffffff, 1, K_OUT_OF_ORDER, 32'hffffffff);
    row(CMD_ACK, 32'hffffffff, 1, K_ACK_UNKNOWN, 32'hffffffff);
    row(CMD_SEND, 0, 1, K_ASSIGNED, 0);
    row(CMD_RECEIVE, 0, 1, K_ACCEPTED, 0);
    row(CMD_RECEIVE, 1, 0, 0, 0);
    row(CMD_FLUSH, 0, 0, 0, 0);
    row(CMD_ACK, 0, 1, K_ACK_MATCHED, 0);
    for (int i = 0; i < 17; i++) row(CMD_SEND, 0, 0, 0, 0);
    foreach (table_rows[i]) begin
      enqueue(table_rows[i].cmd, table_rows[i].seq);
      if (table_rows[i].typed) begin
        drain_one();
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t table row %0d: expected kind %0d seq %0d, nothing predicted", $time, i,
                   table_rows[i].kind, table_rows[i].kseq);
        end else if (expected_words[$].kind !== table_rows[i].kind ||
                     expected_words[$].seq !== table_rows[i].kseq) begin
          errors++;
          $display("%0t table row %0d: expected kind %0d seq %0d, predicted %0d %0d", $time, i,
                   table_rows[i].kind, table_rows[i].kseq, expected_words[$].kind,
                   expected_words[$].seq);
        end
      end
    end
    drain();

    // zero timeout: all sixteen fire every tick
    write_timeout(16'd0);
    enqueue(CMD_TICK, 0);
    enqueue(CMD_TICK, 0);
    drain();

    // fill the ack queue past its depth, then flush
    for (int i = 0; i < 17; i++) begin
      enqueue(CMD_RECEIVE, p_expect_seq);
      drain_one();
    end
    enqueue(CMD_FLUSH, 0);
    drain();

    // short timeout, random traffic with backpressure
    write_timeout(16'd2);
    hold_off = 1;
    fork
      begin
        repeat (150) @(posedge clk);
        hold_off = 0;
      end
      random_phase(30);
    join
    drain();

    no_idle = 1;
    write_timeout(16'd1);
    random_phase(40);
    drain();
    no_idle = 0;

    write_timeout(16'hffff);
    random_phase(20);
    drain();
    write_timeout(16'd3);
    random_phase(20);
    drain();

    $display("ran directed table, timeouts 0/1/2/3/65535, full tables and long stall");
    $display("%0d result words checked", words_seen);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
